/* rtl/core/tppt_pkg.sv */
// Shared widths and constants for the touch pressure pen tracker core.
package tppt_pkg;

  // Sample and product widths
  localparam int unsigned SampleBits = 10;
  localparam int unsigned ProdBits   = 2 * SampleBits;

  // Pressure result: rounding shift, bias and ceiling
  localparam int unsigned PressBits  = 10;
  localparam int unsigned PressShift = 10;
  localparam int unsigned SumBits    = ProdBits + 1;
  localparam logic [SumBits-1:0] RoundBias = SumBits'(1 << (PressShift - 1));
  localparam logic [PressBits-1:0] PressMax = PressBits'((1 << PressBits) - 1);

  // Full-scale reading, treated as zero
  localparam logic [SampleBits-1:0] SampleFull = SampleBits'((1 << SampleBits) - 1);

  // Reset value of the pressure limit register
  localparam logic [PressBits-1:0] MaxPressRst = PressMax;

  // Serial unit step counts
  localparam int unsigned MulSteps   = SampleBits;
  localparam int unsigned DivSteps   = ProdBits;
  localparam int unsigned MulCntBits = $clog2(MulSteps + 1);
  localparam int unsigned DivCntBits = $clog2(DivSteps + 1);

  // Stream data widths, rounded up to whole bytes
  localparam int unsigned InFieldBits  = 1 + 3 * SampleBits;
  localparam int unsigned InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits = PressBits + 2;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

endpackage

/* rtl/core/tppt_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module tppt_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tppt_pkg::SampleBits-1:0] a_i,
  input  logic [tppt_pkg::SampleBits-1:0] b_i,
  output logic                          done_o,
  output logic [tppt_pkg::ProdBits-1:0]   prod_o
);
  import tppt_pkg::*;

  logic                  busy_q, done_q;
  logic [MulCntBits-1:0] cnt_q;
  logic [ProdBits-1:0]   acc_q, acc_d;
  logic [ProdBits-1:0]   mcand_q;
  logic [SampleBits-1:0] mplier_q;

  // Add the shifted multiplicand when the current multiplier bit is set
  always_comb begin
    acc_d = mplier_q[0] ? acc_q + mcand_q : acc_q;
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntBits'(MulSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulate and shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= ProdBits'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= {mcand_q[ProdBits-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[SampleBits-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/core/tppt_div.sv */
// Restoring divider, one quotient bit per cycle.
module tppt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tppt_pkg::ProdBits-1:0]   dividend_i,
  input  logic [tppt_pkg::SampleBits-1:0] divisor_i,
  output logic                            done_o,
  output logic [tppt_pkg::ProdBits-1:0]   quot_o
);
  import tppt_pkg::*;

  logic                  busy_q, done_q;
  logic [DivCntBits-1:0] cnt_q;
  logic [ProdBits-1:0]   dvd_q;
  logic [SampleBits-1:0] rem_q, rem_d;
  logic [SampleBits-1:0] dsr_q;
  logic [SampleBits:0]   trial;
  logic [SampleBits:0]   diff;
  logic                  ge;

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[ProdBits-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? diff[SampleBits-1:0] : trial[SampleBits-1:0];
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntBits'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ProdBits-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

/* rtl/core/touch_pressure_pen_tracker_core.sv */
// Top level of the touch pressure pen tracker: control, pen flag and result register.
//
//  Channel   Dir  Signals                      Contents
//  s_axis    in   tvalid/tready/tdata[31:0]    one touch sample
//  m_axis    out  tvalid/tready/tdata[15:0]    pressure and pen flags
//  cfg       in   cfg_wr_en/cfg_wr_data[9:0]   max_pressure limit
//
// With contact and usable readings the sample runs through 10 multiplier steps,
// the divider load, 20 divider steps, rounding and the output load before the result
// is valid, and input is ready again once the sequencer is back in idle.
// Without contact or with unusable readings the sample goes straight to output load.
// One sample is in work at a time; a stalled output holds the finished sample in
// the sequencer. Reset clears the pen flag and sets the limit to full scale.
module touch_pressure_pen_tracker_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata_i: pen_contact[0], x_plate_sample[10:1], z1_sample[20:11],
  //                 z2_sample[30:21], zero pad[31]
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tppt_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // m_axis_tdata_o: pressure[9:0], touching[10], over_limit[11], zero pad[15:12]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [tppt_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  input  logic                               cfg_wr_en_i,
  input  logic [tppt_pkg::PressBits-1:0]     cfg_wr_data_i
);
  import tppt_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StDone
  } state_e;

  state_e                state_q;
  logic                  contact_q;
  logic [SampleBits-1:0] z1_q;
  logic [PressBits-1:0]  rt_q;
  logic [PressBits-1:0]  max_q;
  logic                  pen_q;
  logic                  out_valid_q;
  logic [PressBits-1:0]  out_press_q;
  logic                  out_touch_q;
  logic                  out_over_q;

  logic                  in_contact;
  logic [SampleBits-1:0] in_x, in_z1, in_z2, x_eff, z_diff;
  logic                  in_ok, accept;
  logic                  mul_done, div_done;
  logic [ProdBits-1:0]   prod, quot;
  logic [SumBits-1:0]    round_sum;
  logic [SumBits-PressShift-1:0] rt_wide;
  logic [PressBits-1:0]  rt_sat;
  logic                  div_start;
  logic                  out_free;
  logic                  out_load;
  logic                  over_now;

  // Unpack the sample and screen out cases that give zero pressure
  always_comb begin
    in_contact = s_axis_tdata_i[0];
    in_x       = s_axis_tdata_i[SampleBits:1];
    in_z1      = s_axis_tdata_i[2*SampleBits:SampleBits+1];
    in_z2      = s_axis_tdata_i[3*SampleBits:2*SampleBits+1];
    x_eff      = (in_x == SampleFull) ? '0 : in_x;
    z_diff     = in_z2 - in_z1;
    in_ok      = in_contact && (x_eff != '0) && (in_z1 != '0) && (in_z2 >= in_z1);
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign div_start       = (state_q == StMul) && mul_done;

  tppt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && in_ok),
    .a_i     (z_diff),
    .b_i     (x_eff),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tppt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (z1_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Round the quotient and clamp to the pressure field
  always_comb begin
    round_sum = SumBits'(quot) + RoundBias;
    rt_wide   = round_sum[SumBits-1:PressShift];
    rt_sat    = (rt_wide > (SumBits-PressShift)'(PressMax)) ? PressMax
                                                            : rt_wide[PressBits-1:0];
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = (state_q == StDone) && out_free;
  assign over_now = rt_q > max_q;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxPressRst;
    end else if (cfg_wr_en_i) begin
      max_q <= cfg_wr_data_i;
    end
  end

  // Sequencer, pen flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      contact_q   <= 1'b0;
      z1_q        <= '0;
      rt_q        <= '0;
      pen_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_press_q <= '0;
      out_touch_q <= 1'b0;
      out_over_q  <= 1'b0;
    end else begin
      // Drop the result once it is transferred and nothing new replaces it
      if (out_valid_q && m_axis_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            contact_q <= in_contact;
            z1_q      <= in_z1;
            rt_q      <= '0;
            state_q   <= in_ok ? StMul : StDone;
          end
        end
        StMul: begin
          if (mul_done) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            rt_q    <= rt_sat;
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_press_q <= rt_q;
            out_over_q  <= contact_q && over_now;
            if (!contact_q) begin
              pen_q       <= 1'b0;
              out_touch_q <= 1'b0;
            end else if (!over_now && (rt_q != '0)) begin
              pen_q       <= 1'b1;
              out_touch_q <= 1'b1;
            end else begin
              out_touch_q <= pen_q;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataBits'({out_over_q, out_touch_q, out_press_q});

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the touch pressure pen tracker core: stream stimulus plus scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tppt_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainCycles = 60;

  // One touch sample and one pressure report, unpacked
  typedef struct packed {
    logic [SampleBits-1:0] z2;
    logic [SampleBits-1:0] z1;
    logic [SampleBits-1:0] x;
    logic                  contact;
  } touch_sample_t;

  typedef struct packed {
    logic                 over_limit;
    logic                 touching;
    logic [PressBits-1:0] pressure;
  } pressure_report_t;

  // Tracks the pen flag and limit, and holds the reports still owed by the core
  class pressure_scoreboard;
    logic [PressBits-1:0] press_limit;
    logic                 pen_flag;
    pressure_report_t     owed_reports[$];
    int unsigned          errors;
    int unsigned          samples_seen;
    int unsigned          reports_seen;
    int unsigned          over_seen;
    int unsigned          pen_flag_seen;

    function new();
      press_limit   = MaxPressRst;
      pen_flag      = 1'b0;
      errors        = 0;
      samples_seen  = 0;
      reports_seen  = 0;
      over_seen     = 0;
      pen_flag_seen = 0;
    endfunction

    // Rounded pressure: ((z2 - z1) * x / z1 + 512) >> 10, zero when unusable
    function logic [PressBits-1:0] touch_pressure(logic [SampleBits-1:0] x,
                                                  logic [SampleBits-1:0] z1,
                                                  logic [SampleBits-1:0] z2);
      logic [SampleBits-1:0] x_eff;
      logic [ProdBits-1:0]   prod;
      logic [ProdBits:0]     rounded;
      logic [ProdBits:0]     scaled;
      x_eff = (x == SampleFull) ? '0 : x;
      if (x_eff == '0 || z1 == '0 || z2 < z1) return '0;
      prod    = ProdBits'(z2 - z1) * ProdBits'(x_eff);
      rounded = (ProdBits + 1)'(prod / ProdBits'(z1)) + (ProdBits + 1)'(512);
      scaled  = rounded >> 10;
      if (scaled > (ProdBits + 1)'(PressMax)) return PressMax;
      return scaled[PressBits-1:0];
    endfunction

    function void set_limit(logic [PressBits-1:0] limit);
      press_limit = limit;
    endfunction

    // Record an accepted sample and queue the report it must produce
    function void note_sample(logic [InDataBits-1:0] data);
      touch_sample_t    smp;
      pressure_report_t rep;
      smp = touch_sample_t'(data[InFieldBits-1:0]);
      rep = '0;
      samples_seen++;
      if (smp.contact) begin
        rep.pressure = touch_pressure(smp.x, smp.z1, smp.z2);
        if (rep.pressure > press_limit) begin
          rep.over_limit = 1'b1;
          over_seen++;
        end else if (rep.pressure != '0) begin
          pen_flag = 1'b1;
        end
      end else begin
        pen_flag = 1'b0;
      end
      rep.touching = pen_flag;
      if (pen_flag) pen_flag_seen++;
      owed_reports.push_back(rep);
    endfunction

    // Compare an accepted report with the oldest one owed
    function void check_result(logic [OutDataBits-1:0] data);
      pressure_report_t got;
      pressure_report_t want;
      got = pressure_report_t'(data[OutFieldBits-1:0]);
      reports_seen++;
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report pressure=%0d touching=%0b over=%0b", $time,
                 got.pressure, got.touching, got.over_limit);
        return;
      end
      want = owed_reports.pop_front();
      if (got.pressure != want.pressure) begin
        errors++;
        $display("%0t: pressure mismatch expected %0d actual %0d", $time,
                 want.pressure, got.pressure);
      end
      if (got.touching != want.touching) begin
        errors++;
        $display("%0t: touching mismatch expected %0b actual %0b", $time,
                 want.touching, got.touching);
      end
      if (got.over_limit != want.over_limit) begin
        errors++;
        $display("%0t: over_limit mismatch expected %0b actual %0b", $time,
                 want.over_limit, got.over_limit);
      end
    endfunction

    function int unsigned pending();
      return owed_reports.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [InDataBits-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OutDataBits-1:0] m_axis_tdata_o;
  logic                   cfg_wr_en_i;
  logic [PressBits-1:0]   cfg_wr_data_i;

  pressure_scoreboard sb;
  int unsigned        idle_cycles;
  int unsigned        limits_written;

  touch_pressure_pen_tracker_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check reports before noting samples taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_sample(s_axis_tdata_i);
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d reports outstanding", $time,
               idle_cycles, sb.pending());
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver backpressure: random ready runs, with some fully open stretches
  initial begin
    int unsigned run_left;
    logic        open_run;
    m_axis_tready_i = 1'b0;
    run_left        = 0;
    open_run        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          open_run = 1'b1;
          run_left = $urandom_range(20, 60);
        end else begin
          open_run = 1'b0;
          run_left = $urandom_range(1, 12);
        end
      end
      m_axis_tready_i = open_run ? 1'b1 : ($urandom_range(0, 2) != 0);
      run_left--;
    end
  end

  function automatic logic [InDataBits-1:0] pack_sample(logic contact, int unsigned x,
                                                       int unsigned z1, int unsigned z2);
    touch_sample_t smp;
    smp.contact = contact;
    smp.x       = SampleBits'(x);
    smp.z1      = SampleBits'(z1);
    smp.z2      = SampleBits'(z2);
    return InDataBits'(smp);
  endfunction

  // Mostly contact samples with usable readings; the rest without contact, or zero, full scale or inverted
  function automatic logic [InDataBits-1:0] random_sample();
    logic        contact;
    int unsigned x;
    int unsigned z1;
    int unsigned z2;
    int unsigned pick;
    contact = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 19);
    if (pick == 0) x = 0;
    else if (pick == 1) x = 1023;
    else x = $urandom_range(1, 1022);
    pick = $urandom_range(0, 15);
    if (pick == 0) z1 = 0;
    else if (pick <= 6) z1 = $urandom_range(1, 31);
    else z1 = $urandom_range(1, 1023);
    if ($urandom_range(0, 9) == 0) z2 = $urandom_range(0, 1023);
    else z2 = $urandom_range(z1, 1023);
    return pack_sample(contact, x, z1, z2);
  endfunction

  // Hold the sample until the core takes it; valid stays up for the next one
  task automatic push_sample(input logic [InDataBits-1:0] data);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = data;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop valid for a number of cycles
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Send a batch in bursts with random gaps, sometimes back to back
  task automatic send_batch(input logic [InDataBits-1:0] batch[$]);
    int unsigned burst_left;
    bit          no_gaps;
    burst_left = 0;
    no_gaps    = ($urandom_range(0, 3) == 0);
    foreach (batch[i]) begin
      if (burst_left == 0) begin
        if (!no_gaps) hold_off($urandom_range(0, 10));
        burst_left = $urandom_range(1, 8);
      end
      push_sample(batch[i]);
      burst_left--;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Wait for every report, then write the pressure limit while the core is idle
  task automatic write_limit(input logic [PressBits-1:0] limit);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b1;
    cfg_wr_data_i = limit;
    sb.set_limit(limit);
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b0;
    limits_written++;
  endtask

  initial begin
    logic [InDataBits-1:0] batch[$];
    logic [PressBits-1:0]  phase_limits[6];
    int unsigned           drain;

    sb              = new();
    idle_cycles     = 0;
    limits_written  = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_wr_en_i     = 1'b0;
    cfg_wr_data_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners under a limit of 100
    write_limit(10'd100);
    batch = {};
    batch.push_back(pack_sample(1'b0, 0, 0, 0));          // no contact, all zero
    batch.push_back(pack_sample(1'b1, 1022, 1, 1023));    // largest pressure, over limit
    batch.push_back(pack_sample(1'b1, 1023, 300, 900));   // full-scale X reads as zero
    batch.push_back(pack_sample(1'b1, 0, 300, 900));      // zero X
    batch.push_back(pack_sample(1'b1, 500, 0, 800));      // zero Z1
    batch.push_back(pack_sample(1'b1, 500, 800, 100));    // Z2 below Z1
    batch.push_back(pack_sample(1'b1, 500, 600, 600));    // Z2 equal to Z1
    batch.push_back(pack_sample(1'b1, 511, 1, 2));        // rounds down to zero
    batch.push_back(pack_sample(1'b1, 512, 1, 2));        // rounds up to one, pen down
    batch.push_back(pack_sample(1'b1, 0, 5, 9));          // zero pressure keeps pen down
    batch.push_back(pack_sample(1'b1, 1000, 5, 1000));    // over limit keeps pen down
    batch.push_back(pack_sample(1'b1, 400, 1, 257));      // exactly at limit
    batch.push_back(pack_sample(1'b1, 404, 1, 257));      // one above limit
    batch.push_back(pack_sample(1'b0, 1023, 1023, 1023)); // no contact, all ones
    batch.push_back(pack_sample(1'b1, 1, 1023, 1023));    // smallest X
    batch.push_back(pack_sample(1'b1, 1022, 1022, 1023)); // tiny difference
    batch.push_back(pack_sample(1'b1, 1022, 1023, 1023)); // largest Z1
    batch.push_back(pack_sample(1'b1, 700, 40, 1023));    // mid range
    batch.push_back(pack_sample(1'b0, 700, 40, 1023));    // lift pen
    send_batch(batch);

    // Random samples across limit settings, extremes included
    phase_limits[0] = 10'd0;
    phase_limits[1] = 10'd1023;
    phase_limits[2] = 10'd1;
    phase_limits[3] = PressBits'($urandom_range(2, 1022));
    phase_limits[4] = 10'd512;
    phase_limits[5] = PressBits'($urandom_range(0, 1023));
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      batch = {};
      repeat (105) batch.push_back(random_sample());
      send_batch(batch);
    end

    // Drain the remaining reports, then let the core settle
    drain = 0;
    while (sb.pending() != 0 && drain < StallLimit * 4) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d reports never arrived", $time, sb.pending());
    end

    $display("Covered %0d samples and %0d reports over %0d limit settings.",
             sb.samples_seen, sb.reports_seen, limits_written);
    $display("Over-limit reports: %0d, reports with pen down: %0d, mismatches: %0d.",
             sb.over_seen, sb.pen_flag_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
